// ===== src/stab_pkg.sv =====
// ----------------------------------------------------------------------------
// stab_pkg: shared types and codes for the sorted table
// Item structs, action and status codes, the controller state type and the
// controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package stab_pkg;

  // default table depth
  localparam int CAPACITY_DEF = 16;

  // action codes carried by an input item
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  // status codes carried by a result item
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_ABSENT = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  // input item
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] occupancy;
  } out_item_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

// ===== src/stab_ctrl.sv =====
// ----------------------------------------------------------------------------
// stab_ctrl: sorted table controller
// Two-state sequencer: takes an item when idle, then runs the update in ST_EXEC.
// ----------------------------------------------------------------------------
module stab_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output stab_pkg::ctrl_t ctrl
);
  import stab_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctrl.load  = 1'b0;
    ctrl.exec  = 1'b0;
    busy       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy       = 1'b1;
        ctrl.exec  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // update cycle is always a single cycle
  a_exec_single: assert property (@(posedge clk) disable iff (rst)
    ctrl.exec |=> !ctrl.exec) else $error("exec held for two cycles");

  // an item is only loaded when the controller is free
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |-> !busy && !ctrl.exec) else $error("load while busy");

  // every load is followed by exactly one update
  a_load_exec: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |=> ctrl.exec) else $error("load not followed by exec");

endmodule

// ===== src/stab_dp.sv =====
// ----------------------------------------------------------------------------
// stab_dp: sorted table datapath
// A row of key cells with a compare in every cell; insert and delete shift
// the cells at and above the lower bound by one place in one update.
// ----------------------------------------------------------------------------
module stab_dp #(
  parameter int CAPACITY = stab_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  stab_pkg::ctrl_t     ctrl,
  input  stab_pkg::in_item_t  cmd,
  output logic                done,
  output stab_pkg::out_item_t result
);
  import stab_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  in_item_t                  item;
  logic signed [31:0]        cells [CAPACITY];
  logic [CntW-1:0]           count;
  logic [CntW-1:0]           count_next;
  logic [CAPACITY-1:0]       valid;
  logic [CAPACITY-1:0]       lt;
  logic [CAPACITY-1:0]       first;
  logic [CAPACITY-1:0]       hit;
  logic                      found;
  logic                      full;
  logic                      do_ins;
  logic                      do_del;
  logic [1:0]                status_next;

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item <= cmd;
    end
  end

  // per-cell compare against the key; lt is a thermometer over the valid prefix
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    assign valid[i] = CntW'(i) < count;
    assign lt[i]    = valid[i] && (cells[i] < item.value);
    if (i == 0) begin : g_first0
      assign first[i] = !lt[i];
    end else begin : g_firstn
      assign first[i] = !lt[i] && lt[i-1];
    end
    assign hit[i] = first[i] && valid[i] && (cells[i] == item.value);
  end

  // decode the action
  always_comb begin
    found       = |hit;
    full        = count == CntW'(CAPACITY);
    do_ins      = 1'b0;
    do_del      = 1'b0;
    count_next  = count;
    status_next = STAT_ABSENT;
    case (item.action)
      ACT_INSERT: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          do_ins      = 1'b1;
          count_next  = count + 1'b1;
          status_next = STAT_OK;
        end
      end
      ACT_SEARCH: begin
        status_next = found ? STAT_OK : STAT_ABSENT;
      end
      ACT_DELETE: begin
        if (found) begin
          do_del      = 1'b1;
          count_next  = count - 1'b1;
          status_next = STAT_OK;
        end
      end
      default: begin
        status_next = STAT_ABSENT;
      end
    endcase
  end

  // cell update: open a gap at the lower bound, or close the one at the hit
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ctrl.exec && !lt[i]) begin
        if (do_ins) begin
          if (first[i]) begin
            cells[i] <= item.value;
          end else begin
            cells[i] <= cells[(i > 0) ? i - 1 : 0];
          end
        end else if (do_del && (i < CAPACITY - 1)) begin
          cells[i] <= cells[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // occupancy counter and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= ctrl.exec;
      if (ctrl.exec) begin
        count <= count_next;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      result.status    <= status_next;
      result.occupancy <= 5'(count_next);
    end
  end

  // occupancy never exceeds the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(CAPACITY)) else $error("count above capacity");

  // a result appears only right after an update cycle
  a_done_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctrl.exec)) else $error("result without update");

  // the table only changes size in an update cycle
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !ctrl.exec |=> $stable(count)) else $error("count changed while idle");

  // a full status is reported only with the table full
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && result.status == STAT_FULL |-> count == CntW'(CAPACITY))
    else $error("full status with room left");

endmodule

// ===== src/sorted_table_insert_search_delete_top.sv =====
// ----------------------------------------------------------------------------
// sorted_table_insert_search_delete_top: bounded sorted multiset of keys
// The item register latches an accepted item, ST_EXEC runs the update, and
// the result strobe and payload are registered at the end of that update.
// No new item is taken while busy; the compare-and-shift cell row does the
// whole update at once after the item is latched.
// The result is shown for one cycle only; the receiver cannot stall it.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_table_insert_search_delete_top #(
  parameter int CAPACITY = stab_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  stab_pkg::in_item_t  cmd,
  output logic                done,
  output stab_pkg::out_item_t result
);
  import stab_pkg::*;

  ctrl_t ctrl;

  // sequencer
  stab_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // cell row and result register
  stab_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

endmodule

// ===== sim/sorted_table_insert_search_delete_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_insert_search_delete_top_tb: self-checking bench for the table
// Runs a directed sequence of insert, search, delete and unused-code items,
// then random items under three sender idle profiles. A local sorted-store
// model predicts status and occupancy for every accepted item. Each strobed
// result is compared field by field against the oldest expectation, hand-written or predicted.
// ----------------------------------------------------------------------------
module sorted_table_insert_search_delete_top_tb;
  import stab_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam int MAX_REPORTS = 10;
  localparam int RAND_PER_PHASE = 330;
  localparam int NUM_DIRECTED = 27;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  // directed row: item plus an optional hand-written expectation
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
    logic               has_exp;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  cmd = '0;
  logic      done;
  out_item_t result;

  // model of the stored keys, ascending signed order
  logic signed [31:0] key_store [CAP];
  int                 key_count = 0;

  out_item_t pending_results [$];
  int        mismatches = 0;
  int        sender_idle_pct = 0;
  int        idle_plan [3] = '{22, 77, 0};

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // empty table: delete, unused code, search all come back absent
    '{ACT_DELETE, 32'sd5,        1'b1, STAT_ABSENT, 5'd0},
    '{ACT_NOP,    32'sd0,        1'b1, STAT_ABSENT, 5'd0},
    '{ACT_SEARCH, 32'sd0,        1'b1, STAT_ABSENT, 5'd0},
    // extremes, zero, minus one and a duplicate
    '{ACT_INSERT, KEY_MAX,       1'b1, STAT_OK,     5'd1},
    '{ACT_INSERT, KEY_MIN,       1'b1, STAT_OK,     5'd2},
    '{ACT_INSERT, 32'sd0,        1'b1, STAT_OK,     5'd3},
    '{ACT_INSERT, -32'sd1,       1'b1, STAT_OK,     5'd4},
    '{ACT_INSERT, 32'sd0,        1'b1, STAT_OK,     5'd5},
    '{ACT_SEARCH, KEY_MIN,       1'b0, STAT_OK,     5'd0},
    '{ACT_SEARCH, 32'sd1,        1'b0, STAT_OK,     5'd0},
    '{ACT_DELETE, 32'sd0,        1'b0, STAT_OK,     5'd0},
    '{ACT_SEARCH, 32'sd0,        1'b0, STAT_OK,     5'd0},
    // fill to capacity with mixed keys and repeats
    '{ACT_INSERT, 32'sd7,        1'b0, STAT_OK,     5'd0},
    '{ACT_INSERT, 32'sd7,        1'b0, STAT_OK,     5'd0},
    '{ACT_INSERT, 32'sh5555_5555, 1'b0, STAT_OK,    5'd0},
    '{ACT_INSERT, 32'shAAAA_AAAA, 1'b0, STAT_OK,    5'd0},
    '{ACT_INSERT, -32'sd100,     1'b0, STAT_OK,     5'd0},
    '{ACT_INSERT, 32'sd100,      1'b0, STAT_OK,     5'd0},
    '{ACT_INSERT, 32'sd1,        1'b0, STAT_OK,     5'd0},
    '{ACT_INSERT, -32'sd2,       1'b0, STAT_OK,     5'd0},
    '{ACT_INSERT, 32'sd2,        1'b0, STAT_OK,     5'd0},
    '{ACT_INSERT, 32'sd3,        1'b0, STAT_OK,     5'd0},
    '{ACT_INSERT, -32'sd7,       1'b0, STAT_OK,     5'd0},
    '{ACT_INSERT, 32'sd7,        1'b1, STAT_OK,     5'd16},
    // full table rejects, then remove the top key
    '{ACT_INSERT, 32'sd4,        1'b1, STAT_FULL,   5'd16},
    '{ACT_DELETE, KEY_MAX,       1'b0, STAT_OK,     5'd0},
    '{ACT_NOP,    -32'sd1,       1'b0, STAT_OK,     5'd0}
  };

  sorted_table_insert_search_delete_top #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // first slot whose key is not less than v
  function automatic int lower_bound_idx(logic signed [31:0] v);
    int i = 0;
    while (i < key_count && key_store[i] < v) i++;
    return i;
  endfunction

  // apply one item to the key store, return status and occupancy
  function automatic out_item_t sorted_apply(in_item_t it);
    out_item_t r;
    int        pos;
    r.status = STAT_ABSENT;
    case (it.action)
      ACT_INSERT: begin
        if (key_count >= CAP) begin
          r.status = STAT_FULL;
        end else begin
          pos = lower_bound_idx(it.value);
          for (int j = key_count; j > pos; j--) key_store[j] = key_store[j-1];
          key_store[pos] = it.value;
          key_count++;
          r.status = STAT_OK;
        end
      end
      ACT_SEARCH: begin
        pos = lower_bound_idx(it.value);
        if (pos < key_count && key_store[pos] == it.value) r.status = STAT_OK;
      end
      ACT_DELETE: begin
        pos = lower_bound_idx(it.value);
        if (pos < key_count && key_store[pos] == it.value) begin
          for (int j = pos; j < key_count - 1; j++) key_store[j] = key_store[j+1];
          key_count--;
          r.status = STAT_OK;
        end
      end
      default: begin
        r.status = STAT_ABSENT;
      end
    endcase
    r.occupancy = 5'(key_count);
    return r;
  endfunction

  // random item, biased toward growing or shrinking the table
  function automatic in_item_t random_item(bit filling);
    in_item_t it;
    int       roll;
    int       pick;
    roll = $urandom_range(0, 99);
    if (roll < 4) it.action = ACT_NOP;
    else if (roll < (filling ? 64 : 34)) it.action = ACT_INSERT;
    else if (roll < (filling ? 80 : 58)) it.action = ACT_SEARCH;
    else it.action = ACT_DELETE;
    pick = $urandom_range(0, 99);
    if (key_count > 0 && pick < 45) begin
      // a stored key, or its neighbor for a near miss
      it.value = key_store[$urandom_range(0, key_count - 1)];
      if (pick < 8) it.value = it.value + 32'sd1;
    end else if (pick < 70) begin
      it.value = $signed($urandom_range(0, 12)) - 6;
    end else if (pick < 80) begin
      case ($urandom_range(0, 3))
        0: it.value = KEY_MIN;
        1: it.value = KEY_MAX;
        2: it.value = 32'sd0;
        default: it.value = -32'sd1;
      endcase
    end else begin
      it.value = $urandom;
    end
    return it;
  endfunction

  // offer one item, hold it until taken, then record its expectation
  task automatic send_item(input in_item_t it, input logic has_exp,
                           input out_item_t hand_exp);
    out_item_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= it;
    // busy only moves at a rising edge, so look at it mid-cycle
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    predicted = sorted_apply(it);
    pending_results.push_back(has_exp ? hand_exp : predicted);
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0d occupancy %0d",
                   result.status, result.occupancy);
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status || result.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected status %0d occupancy %0d, got status %0d occupancy %0d",
                     want.status, want.occupancy, result.status, result.occupancy);
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    in_item_t  it;
    out_item_t hand;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed sequence, no idling
    foreach (directed_rows[i]) begin
      it.action      = directed_rows[i].action;
      it.value       = directed_rows[i].value;
      hand.status    = directed_rows[i].status;
      hand.occupancy = directed_rows[i].occupancy;
      send_item(it, directed_rows[i].has_exp, hand);
    end

    // random items, one phase per idle profile
    hand = '0;
    foreach (idle_plan[p]) begin
      sender_idle_pct = idle_plan[p];
      for (int n = 0; n < RAND_PER_PHASE; n++)
        send_item(random_item(((n / 40) % 2) == 0), 1'b0, hand);
    end
    start <= 1'b0;

    // drain, then wait for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/stab_pkg.sv
src/stab_ctrl.sv
src/stab_dp.sv
src/sorted_table_insert_search_delete_top.sv
sim/sorted_table_insert_search_delete_top_tb.sv
